// ===== hdl/rfae_pkg.sv =====
// Shared types and constants for the register file ALU executor.
package rfae_pkg;

	localparam int REGISTER_COUNT_DEF = 32;
	localparam int WORD_W             = 16;
	localparam int REG_IDX_W          = 5;
	localparam int KIND_W             = 4;
	localparam int MUL_IN_W           = 8;

	typedef logic [KIND_W-1:0]    kind_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [WORD_W-1:0]    word_t;

	typedef enum logic [1:0] {
		STAT_WRITTEN = 2'd0,
		STAT_REFUSED = 2'd1,
		STAT_DIVZERO = 2'd2,
		STAT_UNKNOWN = 2'd3
	} status_t;

	localparam kind_t OP_ADD = 4'd0;
	localparam kind_t OP_SUB = 4'd1;
	localparam kind_t OP_MUL = 4'd2;
	localparam kind_t OP_DIV = 4'd3;
	localparam kind_t OP_AND = 4'd4;

	localparam logic [MUL_IN_W-1:0] MUL_MASK = 8'hFF;

endpackage

// ===== hdl/register_file_alu_executor.sv =====
// Register file ALU executor: one instruction at a time against a synchronous register memory.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------------
//  in      | in_valid / in_stall    | kind, dest_register, source_register,
//          |                        | operand_is_immediate, operand_register, immediate_value
//  out     | out_valid / out_stall  | status, result_value, wrote_register
//
// Both operand registers are read at the transfer edge; the result then passes through EXEC and DONE.
// ADD, SUB, MUL, AND, refusals and unknown codes go from EXEC straight to DONE; DIV first runs
// the restoring divider, one quotient bit per cycle. No new item is taken until DONE is left.
// Reset clears a valid bit per register, so an unwritten register reads as zero at once.
// A held result in the output register does not block the next transfer in; the finished
// item waits there until the output register frees, and only then is the register written.
module register_file_alu_executor #(
	parameter int REGISTER_COUNT = rfae_pkg::REGISTER_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  rfae_pkg::kind_t          kind,
	input  rfae_pkg::reg_idx_t       dest_register,
	input  rfae_pkg::reg_idx_t       source_register,
	input  logic                     operand_is_immediate,
	input  rfae_pkg::reg_idx_t       operand_register,
	input  rfae_pkg::word_t          immediate_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output rfae_pkg::status_t        status,
	output rfae_pkg::word_t          result_value,
	output logic                     wrote_register
);
	import rfae_pkg::*;

	localparam int AW     = $clog2(REGISTER_COUNT);
	localparam int CW     = ((AW > REG_IDX_W) ? AW : REG_IDX_W) + 1;
	localparam int DCNT_W = $clog2(WORD_W);

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cmp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_DONE
	} state_t;

	state_t                   state_q;
	kind_t                    kind_q;
	reg_idx_t                 rd_q;
	logic                     use_imm_q;
	word_t                    imm_q;
	logic                     a_ok_q;
	logic                     b_ok_q;
	word_t                    a_rd_s1;
	word_t                    b_rd_s1;
	word_t                    res_q;
	status_t                  stat_q;
	word_t                    quo_q;
	word_t                    rem_q;
	word_t                    dvs_q;
	logic [DCNT_W-1:0]        cnt_q;
	logic                     out_valid_q;
	status_t                  status_q;
	word_t                    result_q;
	logic                     wrote_q;
	logic [REGISTER_COUNT-1:0] valid_q;

	word_t mem [REGISTER_COUNT];

	logic         in_xfer;
	logic         out_free;
	logic         wr_en;
	cmp_t         rs_ext;
	cmp_t         ro_ext;
	cmp_t         rd_ext;
	addr_t        rs_addr;
	addr_t        ro_addr;
	addr_t        rd_addr;
	logic         rs_in;
	logic         ro_in;
	logic         dest_ok;
	logic         kind_known;
	word_t        op_a;
	word_t        op_b;
	word_t        mul_a;
	word_t        mul_b;
	word_t        alu_res;
	logic [17:0]  trial;
	logic         q_bit;
	word_t        rem_next;
	word_t        quo_next;

	assign in_stall       = (state_q != S_IDLE);
	assign in_xfer        = in_valid && !in_stall;
	assign out_free       = !out_valid_q || !out_stall;
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_value   = result_q;
	assign wrote_register = wrote_q;

	// Indices beyond the file read as zero and refuse a write.
	assign rs_ext  = CW'(source_register);
	assign ro_ext  = CW'(operand_register);
	assign rd_ext  = CW'(rd_q);
	assign rs_addr = AW'(rs_ext);
	assign ro_addr = AW'(ro_ext);
	assign rd_addr = AW'(rd_ext);
	assign rs_in   = (rs_ext < CW'(REGISTER_COUNT));
	assign ro_in   = (ro_ext < CW'(REGISTER_COUNT));
	assign dest_ok = (rd_q != '0) && (rd_ext < CW'(REGISTER_COUNT));

	assign kind_known = (kind_q <= OP_AND);
	assign op_a       = a_ok_q ? a_rd_s1 : '0;
	assign op_b       = use_imm_q ? imm_q : (b_ok_q ? b_rd_s1 : '0);
	assign mul_a      = WORD_W'(op_a[MUL_IN_W-1:0] & MUL_MASK);
	assign mul_b      = WORD_W'(op_b[MUL_IN_W-1:0] & MUL_MASK);

	always_comb begin
		case (kind_q)
			OP_ADD:  alu_res = op_a + op_b;
			OP_SUB:  alu_res = op_a - op_b;
			OP_MUL:  alu_res = mul_a * mul_b;
			default: alu_res = op_a & op_b;
		endcase
	end

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	assign trial    = {1'b0, rem_q, quo_q[WORD_W-1]} - {2'b00, dvs_q};
	assign q_bit    = !trial[17];
	assign rem_next = q_bit ? trial[WORD_W-1:0] : {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
	assign quo_next = {quo_q[WORD_W-2:0], q_bit};

	assign wr_en = (state_q == S_DONE) && out_free && (stat_q == STAT_WRITTEN);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			a_rd_s1 <= mem[rs_addr];
			b_rd_s1 <= mem[ro_addr];
		end
		if (wr_en) begin
			mem[rd_addr] <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[rd_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= OP_ADD;
			rd_q        <= '0;
			use_imm_q   <= 1'b0;
			imm_q       <= '0;
			a_ok_q      <= 1'b0;
			b_ok_q      <= 1'b0;
			res_q       <= '0;
			stat_q      <= STAT_WRITTEN;
			quo_q       <= '0;
			rem_q       <= '0;
			dvs_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_WRITTEN;
			result_q    <= '0;
			wrote_q     <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						kind_q    <= kind;
						rd_q      <= dest_register;
						use_imm_q <= operand_is_immediate;
						imm_q     <= immediate_value;
						a_ok_q    <= rs_in && valid_q[rs_addr];
						b_ok_q    <= ro_in && valid_q[ro_addr];
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					res_q   <= '0;
					if (!kind_known) begin
						stat_q <= STAT_UNKNOWN;
					end else if (!dest_ok) begin
						stat_q <= STAT_REFUSED;
					end else if (kind_q == OP_DIV) begin
						if (op_b == '0) begin
							stat_q <= STAT_DIVZERO;
						end else begin
							quo_q   <= op_a;
							rem_q   <= '0;
							dvs_q   <= op_b;
							cnt_q   <= DCNT_W'(WORD_W - 1);
							state_q <= S_DIV;
						end
					end else begin
						stat_q <= STAT_WRITTEN;
						res_q  <= alu_res;
					end
				end
				S_DIV: begin
					quo_q <= quo_next;
					rem_q <= rem_next;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						res_q   <= quo_next;
						stat_q  <= STAT_WRITTEN;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold until the output register frees, then publish and write back.
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= stat_q;
						result_q    <= res_q;
						wrote_q     <= (stat_q == STAT_WRITTEN);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/register_file_alu_executor_tb.sv =====
// Self-checking testbench for the register file ALU executor, with a predicting scoreboard.
`timescale 1ns / 100ps

module register_file_alu_executor_tb;
	import rfae_pkg::*;

	localparam int NREGS = REGISTER_COUNT_DEF;
	localparam kind_t KIND_UNKNOWN_LO = 4'd5;
	localparam kind_t KIND_MAX = 4'd15;
	localparam int IDLE_PCT = 21;
	localparam int RANDOM_ITEMS = 1750;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;
	localparam int MAX_PRINTED = 100;

	typedef struct packed {
		kind_t    kind;
		reg_idx_t rd;
		reg_idx_t rs;
		logic     use_imm;
		reg_idx_t ro;
		word_t    imm;
	} instr_t;

	class exec_scoreboard;
		typedef struct packed {
			status_t status;
			word_t   value;
			logic    wrote;
		} outcome_t;

		word_t    regs [NREGS];
		outcome_t outcome_q [$];
		int       errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			errors = 0;
		endfunction

		function word_t read_reg(reg_idx_t idx);
			if (idx >= NREGS)
				return '0;
			return regs[idx];
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("%0t MISMATCH: %s", $realtime, msg);
		endtask

		// Execute an accepted instruction and queue the result it must produce.
		function void note_instr(instr_t it);
			word_t    a;
			word_t    b;
			word_t    r;
			outcome_t o;
			o.status = STAT_WRITTEN;
			o.value  = '0;
			o.wrote  = 1'b0;
			r        = '0;
			if (it.kind > OP_AND) begin
				o.status = STAT_UNKNOWN;
			end else if (it.rd == 0 || it.rd >= NREGS) begin
				o.status = STAT_REFUSED;
			end else begin
				a = read_reg(it.rs);
				b = it.use_imm ? it.imm : read_reg(it.ro);
				case (it.kind)
					OP_ADD: r = a + b;
					OP_SUB: r = a - b;
					OP_MUL: r = word_t'(a[MUL_IN_W-1:0]) * word_t'(b[MUL_IN_W-1:0]);
					OP_DIV: begin
						if (b == 0)
							o.status = STAT_DIVZERO;
						else
							r = a / b;
					end
					default: r = a & b;
				endcase
				if (o.status == STAT_WRITTEN) begin
					regs[it.rd] = r;
					o.value     = r;
					o.wrote     = 1'b1;
				end
			end
			outcome_q.push_back(o);
		endfunction

		task check_result(status_t st, word_t v, logic w);
			outcome_t o;
			if (outcome_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d value=%h", st, v));
				return;
			end
			o = outcome_q.pop_front();
			if (st !== o.status)
				report_mismatch($sformatf("status %0d, expected %0d", st, o.status));
			if (v !== o.value)
				report_mismatch($sformatf("result_value %h, expected %h", v, o.value));
			if (w !== o.wrote)
				report_mismatch($sformatf("wrote_register %b, expected %b", w, o.wrote));
		endtask
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	kind_t    kind;
	reg_idx_t dest_register;
	reg_idx_t source_register;
	logic     operand_is_immediate;
	reg_idx_t operand_register;
	word_t    immediate_value;
	logic     out_valid;
	logic     out_stall;
	status_t  status;
	word_t    result_value;
	logic     wrote_register;

	logic calm;
	logic hold_off_req;
	logic hold_off_done;

	exec_scoreboard sb = new();

	register_file_alu_executor i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.kind                (kind),
		.dest_register       (dest_register),
		.source_register     (source_register),
		.operand_is_immediate(operand_is_immediate),
		.operand_register    (operand_register),
		.immediate_value     (immediate_value),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.status              (status),
		.result_value        (result_value),
		.wrote_register      (wrote_register)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random stall, one long hold-off on request, none while calm.
	initial begin
		out_stall     = 1'b0;
		hold_off_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				out_stall     = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			out_stall = calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, result_value, wrote_register);
	end

	// Present one instruction from a falling edge and hold it until the transfer.
	task automatic send_instr(instr_t it);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind                 = it.kind;
		dest_register        = it.rd;
		source_register      = it.rs;
		operand_is_immediate = it.use_imm;
		operand_register     = it.ro;
		immediate_value      = it.imm;
		in_valid             = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_instr(it);
		@(negedge clk);
	endtask

	task automatic send_dir(kind_t k, reg_idx_t rd, reg_idx_t rs, logic ui, reg_idx_t ro,
			word_t imm);
		instr_t it;
		it = '{kind: k, rd: rd, rs: rs, use_imm: ui, ro: ro, imm: imm};
		send_instr(it);
	endtask

	task automatic wait_drain();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	function automatic instr_t rand_instr();
		instr_t it;
		int     sel;
		sel = $urandom_range(99);
		if (sel < 88)
			it.kind = kind_t'($urandom_range(OP_AND));
		else
			it.kind = kind_t'($urandom_range(KIND_MAX, KIND_UNKNOWN_LO));
		it.rd      = ($urandom_range(99) < 8) ? reg_idx_t'(0) : reg_idx_t'($urandom_range(31, 1));
		it.rs      = reg_idx_t'($urandom_range(31));
		it.ro      = reg_idx_t'($urandom_range(31));
		it.use_imm = 1'($urandom_range(1));
		sel        = $urandom_range(9);
		if (sel == 0)
			it.imm = '0;
		else if (sel < 4)
			it.imm = word_t'($urandom_range(15, 1));
		else
			it.imm = word_t'($urandom_range(16'hFFFF));
		return it;
	endfunction

	initial begin
		calm                 = 1'b0;
		hold_off_req         = 1'b0;
		arst_n               = 1'b0;
		in_valid             = 1'b0;
		kind                 = OP_ADD;
		dest_register        = '0;
		source_register      = '0;
		operand_is_immediate = 1'b0;
		operand_register     = '0;
		immediate_value      = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Wrap, extreme operands, divide by zero, refused destination, unknown codes.
		send_dir(OP_ADD, 1, 0, 1'b1, 0, 16'hFFFF);
		send_dir(OP_ADD, 2, 1, 1'b1, 0, 16'h0001);
		send_dir(OP_SUB, 3, 0, 1'b1, 0, 16'h0001);
		send_dir(OP_SUB, 4, 3, 1'b0, 1, 16'h0000);
		send_dir(OP_MUL, 5, 3, 1'b0, 1, 16'h0000);
		send_dir(OP_MUL, 6, 5, 1'b1, 0, 16'h0100);
		send_dir(OP_DIV, 7, 3, 1'b1, 0, 16'h0000);
		send_dir(OP_DIV, 7, 3, 1'b0, 0, 16'hFFFF);
		send_dir(OP_DIV, 7, 3, 1'b1, 0, 16'h0001);
		send_dir(OP_DIV, 8, 5, 1'b0, 3, 16'h0000);
		send_dir(OP_DIV, 9, 0, 1'b1, 0, 16'hFFFF);
		send_dir(OP_AND, 31, 3, 1'b1, 0, 16'hA5A5);
		send_dir(OP_AND, 30, 31, 1'b0, 31, 16'h5A5A);
		send_dir(OP_ADD, 0, 3, 1'b1, 0, 16'h0001);
		send_dir(OP_DIV, 0, 3, 1'b1, 0, 16'h0000);
		for (int k = KIND_UNKNOWN_LO; k <= KIND_MAX; k++)
			send_dir(kind_t'(k), reg_idx_t'(k[0] ? 31 : 0), 31, k[1], 31, 16'hFFFF);
		wait_drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 400)
				hold_off_req = 1'b1;
			calm = (n >= 700 && n < 1000);
			// Pause the sender until the block has emptied.
			if (n == 1100)
				wait_drain();
			send_instr(rand_instr());
		end
		calm = 1'b0;

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== register_file_alu_executor.f =====
hdl/rfae_pkg.sv
hdl/register_file_alu_executor.sv
tb/register_file_alu_executor_tb.sv
